/* hdl/sv32_tlb_with_plru_defines.svh */
// Assertion macros used by the checker file of the translation buffer.
`ifndef SV32_TLB_WITH_PLRU_DEFINES_SVH
`define SV32_TLB_WITH_PLRU_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define SV32TLB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define SV32TLB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/sv32tlb_pkg.sv */
`timescale 1ns / 1ps

package sv32tlb_pkg;

  localparam int unsigned Entries     = 32;
  localparam int unsigned TreeLevels  = 5;
  localparam int unsigned PayloadBits = 32;

  localparam int unsigned IdxW   = $clog2(Entries);
  localparam int unsigned NodeW  = (TreeLevels + 1 > IdxW + 1) ? TreeLevels + 1 : IdxW + 1;
  localparam int unsigned HalfW  = 10;
  localparam int unsigned VpnW   = 2 * HalfW;
  localparam int unsigned AsidW  = 9;
  localparam int unsigned ActionW = 2;
  localparam int unsigned SlotW  = 5;
  localparam int unsigned InPayW = 32;
  localparam int unsigned OutPayW = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_FILL,
    OP_FLUSH,
    OP_NOP
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CURRENT_ASID = 1'b0,
    CFG_REPL_MODE    = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    REPL_ROTATE = 1'b0,
    REPL_PLRU   = 1'b1
  } repl_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CMP,
    BK_SEL,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    op_e                    op;
    logic [HalfW-1:0]       vpn1;
    logic [HalfW-1:0]       vpn0;
    logic [AsidW-1:0]       asid;
    logic                   mega;
    logic [PayloadBits-1:0] pay;
    logic                   asid_all;
    logic                   page_all;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t item;
  } queue_port_t;

  typedef struct packed {
    logic                we;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [HalfW-1:0] vpn1;
    logic [HalfW-1:0] vpn0;
    logic [AsidW-1:0] asid;
  } tag_t;

  // Walks the tree from the root; nodes outside the stored tree read as zero.
  function automatic logic [IdxW-1:0] tree_victim(input logic [Entries-2:0] plru);
    logic [NodeW-1:0] node;
    logic             dir;
    node = '0;
    for (int l = 0; l < TreeLevels; l++) begin
      dir  = (node < NodeW'(Entries - 1)) ? plru[IdxW'(node)] : 1'b0;
      node = dir ? (node << 1) + NodeW'(2) : (node << 1) + NodeW'(1);
    end
    if (node < NodeW'(Entries - 1) || node - NodeW'(Entries - 1) >= NodeW'(Entries)) begin
      return '0;
    end
    return IdxW'(node - NodeW'(Entries - 1));
  endfunction

  // Points every node on the path of the slot away from it.
  function automatic logic [Entries-2:0] plru_touch(input logic [Entries-2:0] plru,
                                                    input logic [IdxW-1:0] slot);
    logic [NodeW-1:0]   cur;
    logic [NodeW-1:0]   parent;
    logic [Entries-2:0] res;
    res    = plru;
    cur    = NodeW'(slot) + NodeW'(Entries - 1);
    parent = '0;
    for (int k = 0; k < IdxW; k++) begin
      if (cur != '0) begin
        parent = (cur - NodeW'(1)) >> 1;
        res[IdxW'(parent)] = cur[0];
        cur = parent;
      end
    end
    return res;
  endfunction

  function automatic logic [IdxW-1:0] first_set(input logic [Entries-1:0] vec);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* hdl/sv32tlb_if.sv */
`timescale 1ns / 1ps

interface sv32tlb_req_if;
  logic                              valid;
  logic                              ready;
  logic [sv32tlb_pkg::ActionW-1:0]   action;
  logic [sv32tlb_pkg::VpnW-1:0]      page_number;
  logic [sv32tlb_pkg::AsidW-1:0]     space_id;
  logic                              is_megapage;
  logic [sv32tlb_pkg::InPayW-1:0]    entry_payload;

  modport source (output valid, action, page_number, space_id, is_megapage, entry_payload,
                  input ready);
  modport sink (input valid, action, page_number, space_id, is_megapage, entry_payload,
                output ready);
endinterface

interface sv32tlb_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic                              multi_hit;
  logic [sv32tlb_pkg::SlotW-1:0]     slot_index;
  logic                              hit_megapage;
  logic [sv32tlb_pkg::OutPayW-1:0]   hit_payload;

  modport source (output valid, hit, multi_hit, slot_index, hit_megapage, hit_payload,
                  input ready);
  modport sink (input valid, hit, multi_hit, slot_index, hit_megapage, hit_payload,
                output ready);
endinterface

/* hdl/sv32tlb_queue.sv */
`timescale 1ns / 1ps

module sv32tlb_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sv32tlb_pkg::queue_port_t push_i,
  output logic                     full_o,
  output sv32tlb_pkg::queue_port_t q_o,
  input  logic                     pop_i
);
  import sv32tlb_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  req_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign q_o.valid = (cnt_q != '0);
  assign q_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i.valid && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i.valid && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

/* hdl/sv32tlb_front.sv */
`timescale 1ns / 1ps

module sv32tlb_front (
  sv32tlb_req_if.sink              req_i,
  input  logic                     q_full_i,
  output sv32tlb_pkg::queue_port_t push_o
);
  import sv32tlb_pkg::*;

  req_t item;

  assign req_i.ready  = !q_full_i;
  assign push_o.valid = req_i.valid && !q_full_i;
  assign push_o.item  = item;

  always_comb begin
    item.vpn1     = req_i.page_number[VpnW-1:HalfW];
    item.vpn0     = req_i.page_number[HalfW-1:0];
    item.asid     = req_i.space_id;
    item.mega     = req_i.is_megapage;
    item.pay      = PayloadBits'(req_i.entry_payload);
    item.asid_all = (req_i.space_id == '0);
    item.page_all = (req_i.page_number == '0);
    unique case (action_e'(req_i.action))
      ACT_LOOKUP: item.op = OP_LOOKUP;
      ACT_FILL:   item.op = OP_FILL;
      ACT_FLUSH:  item.op = OP_FLUSH;
      default:    item.op = OP_NOP;
    endcase
  end

endmodule

/* hdl/sv32tlb_back.sv */
`timescale 1ns / 1ps

module sv32tlb_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sv32tlb_pkg::queue_port_t q_i,
  output logic                     q_pop_o,
  input  sv32tlb_pkg::cfg_wr_t     cfg_i,
  sv32tlb_rsp_if.source            rsp_o
);
  import sv32tlb_pkg::*;

  back_state_e state_q, state_d;
  req_t        item_q;
  logic [Entries-1:0] vec_q, vec_d;
  logic [Entries-1:0] lk_match, fl_match;

  logic [Entries-1:0]     valid_q;
  tag_t                   tag_q [Entries];
  logic [Entries-1:0]     mega_q;
  logic [PayloadBits-1:0] pay_mem [Entries];
  logic [PayloadBits-1:0] rd_q;
  logic [Entries-2:0]     plru_q;
  logic [IdxW-1:0]        rot_q;
  logic [AsidW-1:0]       asid_q;
  repl_e                  mode_q;

  logic            res_hit_q, res_multi_q, res_mega_q;
  logic [IdxW-1:0] res_slot_q;

  logic               out_valid_q;
  logic               out_hit_q, out_multi_q, out_mega_q;
  logic [SlotW-1:0]   out_slot_q;
  logic [OutPayW-1:0] out_pay_q;

  logic            load_item, out_load, out_free;
  logic            any_set, multi, lookup_hit, is_fill;
  logic [IdxW-1:0] first_idx, victim, fill_slot, touch_slot;

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      lk_match[i] = valid_q[i] && (tag_q[i].vpn1 == item_q.vpn1) &&
                    (tag_q[i].asid == asid_q) &&
                    (mega_q[i] || (tag_q[i].vpn0 == item_q.vpn0));
      fl_match[i] = valid_q[i] && (item_q.asid_all || (tag_q[i].asid == item_q.asid)) &&
                    (item_q.page_all || ((tag_q[i].vpn1 == item_q.vpn1) &&
                     (mega_q[i] || (tag_q[i].vpn0 == item_q.vpn0))));
    end
    unique case (item_q.op)
      OP_LOOKUP: vec_d = lk_match;
      OP_FILL:   vec_d = ~valid_q;
      OP_FLUSH:  vec_d = fl_match;
      default:   vec_d = '0;
    endcase
  end

  assign first_idx  = first_set(vec_q);
  assign any_set    = |vec_q;
  assign multi      = |(vec_q & (vec_q - Entries'(1)));
  assign is_fill    = (item_q.op == OP_FILL);
  assign lookup_hit = (item_q.op == OP_LOOKUP) && any_set && !multi;
  assign victim     = (mode_q == REPL_PLRU) ? tree_victim(plru_q) :
                      ((rot_q == IdxW'(Entries - 1)) ? '0 : rot_q + IdxW'(1));
  assign fill_slot  = any_set ? first_idx : victim;
  assign touch_slot = is_fill ? fill_slot : first_idx;

  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    load_item = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_i.valid) begin
          q_pop_o   = 1'b1;
          load_item = 1'b1;
          state_d   = BK_CMP;
        end
      end
      BK_CMP: state_d = BK_SEL;
      BK_SEL: state_d = BK_OUT;
      BK_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (q_i.valid) begin
            q_pop_o   = 1'b1;
            load_item = 1'b1;
            state_d   = BK_CMP;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      plru_q      <= '0;
      rot_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == BK_SEL) begin
        if (is_fill) begin
          valid_q[fill_slot] <= 1'b1;
          rot_q              <= fill_slot;
        end else if (item_q.op == OP_FLUSH) begin
          valid_q <= valid_q & ~vec_q;
        end
        if (is_fill || lookup_hit) begin
          plru_q <= plru_touch(plru_q, touch_slot);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asid_q <= '0;
      mode_q <= REPL_PLRU;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_CURRENT_ASID: asid_q <= AsidW'(cfg_i.data);
        CFG_REPL_MODE:    mode_q <= repl_e'(cfg_i.data[0]);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_item) begin
      item_q <= q_i.item;
    end
    if (state_q == BK_CMP) begin
      vec_q <= vec_d;
    end
    if (state_q == BK_SEL) begin
      if (is_fill) begin
        tag_q[fill_slot]   <= '{vpn1: item_q.vpn1, vpn0: item_q.vpn0, asid: item_q.asid};
        mega_q[fill_slot]  <= item_q.mega;
        pay_mem[fill_slot] <= item_q.pay;
      end
      rd_q        <= pay_mem[first_idx];
      res_hit_q   <= lookup_hit;
      res_multi_q <= (item_q.op == OP_LOOKUP) && multi;
      res_mega_q  <= lookup_hit && mega_q[first_idx];
      res_slot_q  <= is_fill ? fill_slot : (lookup_hit ? first_idx : '0);
    end
    if (out_load) begin
      out_hit_q   <= res_hit_q;
      out_multi_q <= res_multi_q;
      out_mega_q  <= res_mega_q;
      out_slot_q  <= SlotW'(res_slot_q);
      out_pay_q   <= res_hit_q ? OutPayW'(rd_q) : '0;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.hit          = out_hit_q;
  assign rsp_o.multi_hit    = out_multi_q;
  assign rsp_o.slot_index   = out_slot_q;
  assign rsp_o.hit_megapage = out_mega_q;
  assign rsp_o.hit_payload  = out_pay_q;

endmodule

/* hdl/sv32_tlb_with_plru.sv */
`timescale 1ns / 1ps
// Fully associative Sv32 translation buffer with tree pseudo-LRU replacement.
// Requests arrive on req_i as valid/ready items carrying an action (lookup,
// fill or flush), the virtual page number, an ASID, a megapage flag and the
// entry payload. Every request yields exactly one result item on rsp_o.
// Configuration (current ASID, replacement mode) is written through
// cfg_we_i, cfg_idx_i and cfg_data_i; the user must write it only while no
// request is in flight, as the block itself does not enforce this. Each
// accepted item steps through the execution sequencer (compare all tags,
// resolve and update, hand off), which starts the next item at hand-off.
// A two-entry queue decouples acceptance from execution, so up to two
// requests are taken ahead while the result register waits on rsp_o.ready.
// When the receiver stalls, the result holds steady, the sequencer stops at
// the hand-off step, and req_i.ready drops once the queue is full.
// Reset clears every valid bit, the PLRU tree and the rotating pointer, sets
// the current ASID to zero and selects PLRU replacement; no clearing pass is
// needed and requests are accepted as soon as reset is released.
module sv32_tlb_with_plru (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sv32tlb_req_if.sink                      req_i,
  sv32tlb_rsp_if.source                    rsp_o,
  input  logic                             cfg_we_i,
  input  logic [sv32tlb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sv32tlb_pkg::CfgDataW-1:0] cfg_data_i
);
  import sv32tlb_pkg::*;

  queue_port_t push, q_head;
  logic        q_full, q_pop;
  cfg_wr_t     cfg_wr;

  assign cfg_wr = '{we: cfg_we_i, idx: cfg_idx_e'(cfg_idx_i), data: cfg_data_i};

  sv32tlb_front u_front (
    .req_i    (req_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  sv32tlb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .q_o    (q_head),
    .pop_i  (q_pop)
  );

  sv32tlb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_i     (q_head),
    .q_pop_o (q_pop),
    .cfg_i   (cfg_wr),
    .rsp_o   (rsp_o)
  );

endmodule

/* hdl/sv32tlb_checker.sv */
`timescale 1ns / 1ps
`include "sv32_tlb_with_plru_defines.svh"

module sv32tlb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic                            hit_i,
  input logic                            multi_hit_i,
  input logic [sv32tlb_pkg::SlotW-1:0]   slot_index_i,
  input logic                            hit_megapage_i,
  input logic [sv32tlb_pkg::OutPayW-1:0] hit_payload_i
);
  import sv32tlb_pkg::*;

  `SV32TLB_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(hit_i) && $stable(multi_hit_i) && $stable(slot_index_i) && $stable(hit_megapage_i) && $stable(hit_payload_i), "stalled result item changed")
  `SV32TLB_ASSERT(a_multi_clean, clk_i, rst_ni, rsp_valid_i && multi_hit_i |-> !hit_i && (slot_index_i == '0) && !hit_megapage_i && (hit_payload_i == '0), "multiple hit item carries hit data")
  `SV32TLB_ASSERT(a_miss_clean, clk_i, rst_ni, rsp_valid_i && !hit_i |-> !hit_megapage_i && (hit_payload_i == '0), "item without hit carries entry data")
  `SV32TLB_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !rsp_valid_i, "result valid during reset")

endmodule

bind sv32_tlb_with_plru sv32tlb_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .hit_i          (rsp_o.hit),
  .multi_hit_i    (rsp_o.multi_hit),
  .slot_index_i   (rsp_o.slot_index),
  .hit_megapage_i (rsp_o.hit_megapage),
  .hit_payload_i  (rsp_o.hit_payload)
);
